// ===== rtl/core/eps_pkg.sv =====
// Shared types and constants for the encoder position and speed core.
// Used by eps_div and encoder_position_speed_core; no dependencies.
`default_nettype none

package eps_pkg;

	// Item function codes
	localparam logic [1:0] FUNC_WRAP   = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_RESET  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Register index map
	localparam logic REG_PPR = 1'b0;

	localparam logic [15:0] PPR_RESET = 16'd1024;

	// Channel storage follows the one-bit channel field
	localparam int CHAN_CNT = 2;

	// 60 s/min * 1000 ms/s * 256 (Q8)
	localparam logic [23:0] RPM_SCALE = 24'd15360000;
	localparam logic [31:0] WRAP_STEP = 32'h0001_0000;

	// Divider widths: numerator < 2^55, denominator < 2^48
	localparam int NUM_W = 56;
	localparam int DEN_W = 48;
	localparam int QUO_W = 33;

	// Divider response
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quot;  // quotient clamped to 2^32
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/eps_div.sv =====
// Restoring divider, one quotient bit per cycle, quotient clamped to 2^32.
// Depends on eps_pkg.
`default_nettype none

module eps_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [eps_pkg::NUM_W-1:0]  num,
	input  wire logic [eps_pkg::DEN_W-1:0]  den,
	output eps_pkg::div_rsp_t               rsp
);
	import eps_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] num_q;
	logic [QUO_W-1:0] quot_q;
	logic             ovf_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step
	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		diff   = rem_sh - {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			den_q  <= den;
			num_q  <= num;
			quot_q <= '0;
			ovf_q  <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[QUO_W-2:0], ge};
			ovf_q  <= ovf_q | quot_q[QUO_W-1];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = (ovf_q || quot_q[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : quot_q;

endmodule

`default_nettype wire

// ===== rtl/core/encoder_position_speed_core.sv =====
// Top level of the two-channel encoder position and speed core.
// Depends on eps_pkg and eps_div.
`default_nettype none

// Extends each channel's 16-bit counter to a 32-bit signed position and
// measures speed in rpm (signed Q23.8, saturated) on sample requests. One
// request is handled at a time: wrap and position-reset requests pass
// through the calculate and done states; a sample request with a nonzero
// interval also runs a 56-step restoring divider and one shared multiplier
// that forms numerator and denominator in turn. A finished result may wait
// in the output register while the next request is taken. Requests with
// function code 3 or a channel at or above NUM_CHANNELS are dropped without
// a result. pulses_per_rev sits at byte address 0; a value of 0 acts as 1.
module encoder_position_speed_core #(
	parameter int NUM_CHANNELS = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         func,
	input  wire logic               channel,
	input  wire logic [15:0]        raw_count,
	input  wire logic               count_down,
	input  wire logic [31:0]        now_ms,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    out_channel,
	output logic signed [31:0]      position,
	output logic signed [31:0]      rpm_q8,
	output logic                    rpm_updated,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import eps_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CALC = 3'd1;
	localparam logic [2:0] S_MNUM = 3'd2;
	localparam logic [2:0] S_MDEN = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]  state_q;
	logic [15:0] ppr_q;

	// latched request
	logic [1:0]  func_q;
	logic        ch_q;
	logic [15:0] raw_q;
	logic        down_q;
	logic [31:0] now_q;

	// per-channel state
	logic [31:0] hp_q        [CHAN_CNT];
	logic [31:0] prev_pos_q  [CHAN_CNT];
	logic [31:0] prev_time_q [CHAN_CNT];
	logic [31:0] speed_q     [CHAN_CNT];

	// working registers
	logic [31:0]      pos_q;
	logic [31:0]      mag_q;
	logic             neg_q;
	logic [31:0]      dt_q;
	logic [NUM_W-1:0] num_q;
	logic             upd_q;

	logic             out_valid_q;
	logic             out_ch_q;
	logic [31:0]      out_pos_q;
	logic [31:0]      out_rpm_q;
	logic             out_upd_q;

	logic             accept;
	logic             load_out;
	logic             ch_ok;
	logic [31:0]      hp_cur;
	logic [31:0]      hp_new;
	logic [31:0]      pos_calc;
	logic [31:0]      delta;
	logic [31:0]      dt_calc;
	logic [15:0]      ppr_eff;
	logic [31:0]      mul_a;
	logic [23:0]      mul_b;
	logic [NUM_W-1:0] mul_p;
	logic             div_start;
	div_rsp_t         div_rsp;
	logic [31:0]      rpm_sat;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign ch_ok    = int'(ch_q) < NUM_CHANNELS;

	// Position and interval for the latched request
	always_comb begin
		hp_cur = hp_q[ch_q];
		unique case (func_q)
			FUNC_WRAP:   hp_new = down_q ? hp_cur - WRAP_STEP : hp_cur + WRAP_STEP;
			FUNC_RESET:  hp_new = '0;
			default:     hp_new = hp_cur;
		endcase
		pos_calc = hp_new + {16'b0, raw_q};
		delta    = pos_calc - prev_pos_q[ch_q];
		dt_calc  = now_q - prev_time_q[ch_q];
	end

	// Shared multiplier: numerator first, then denominator
	always_comb begin
		ppr_eff = (ppr_q == '0) ? 16'd1 : ppr_q;
		if (state_q == S_MNUM) begin
			mul_a = mag_q;
			mul_b = RPM_SCALE;
		end else begin
			mul_a = dt_q;
			mul_b = {8'b0, ppr_eff};
		end
		mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
	end

	assign div_start = (state_q == S_MDEN);

	eps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (mul_p[DEN_W-1:0]),
		.rsp    (div_rsp)
	);

	// Signed saturation of the quotient magnitude
	always_comb begin
		if (!neg_q) begin
			rpm_sat = (div_rsp.quot > QUO_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
			                                                 : div_rsp.quot[31:0];
		end else begin
			rpm_sat = (div_rsp.quot > QUO_W'(32'h8000_0000)) ? 32'h8000_0000
			                                                 : 32'd0 - div_rsp.quot[31:0];
		end
	end

	// Sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < CHAN_CNT; i++) begin
				hp_q[i]        <= '0;
				prev_pos_q[i]  <= '0;
				prev_time_q[i] <= '0;
				speed_q[i]     <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (func_q == FUNC_UNUSED || !ch_ok) begin
						state_q <= S_IDLE;
					end else begin
						hp_q[ch_q] <= hp_new;
						if (func_q == FUNC_SAMPLE) begin
							prev_pos_q[ch_q]  <= pos_calc;
							prev_time_q[ch_q] <= now_q;
						end
						state_q <= (func_q == FUNC_SAMPLE && dt_calc != '0) ? S_MNUM : S_DONE;
					end
				end
				S_MNUM: state_q <= S_MDEN;
				S_MDEN: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						speed_q[ch_q] <= rpm_sat;
						state_q       <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request and working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			ch_q   <= channel;
			raw_q  <= raw_count;
			down_q <= count_down;
			now_q  <= now_ms;
		end
		if (state_q == S_CALC) begin
			pos_q <= pos_calc;
			neg_q <= delta[31];
			mag_q <= delta[31] ? 32'd0 - delta : delta;
			dt_q  <= dt_calc;
			upd_q <= (func_q == FUNC_SAMPLE) && (dt_calc != '0);
		end
		if (state_q == S_MNUM) begin
			num_q <= mul_p;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q  <= ch_q;
			out_pos_q <= pos_q;
			out_rpm_q <= speed_q[ch_q];
			out_upd_q <= upd_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_ch_q;
	assign position    = signed'(out_pos_q);
	assign rpm_q8      = signed'(out_rpm_q);
	assign rpm_updated = out_upd_q;

	// Configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q <= PPR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_PPR)) begin
			ppr_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PPR) ? {16'b0, ppr_q} : 32'd0;

`ifndef SYNTHESIS
	// A new speed is only reported for sample requests
	a_upd_sample: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && upd_q |-> func_q == FUNC_SAMPLE)
		else $error("speed update on non-sample request");

	// Divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// The sequencer leaves the divide state only on completion
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && !div_rsp.done |=> state_q == S_DIV)
		else $error("left divide state early");
`endif

endmodule

`default_nettype wire
